// ===== hdl/tpeg_pkg.sv =====
// Shared constants and types for the tanh pipeline.
package tpeg_pkg;

  // Signed Q23.40 working value
  typedef logic signed [63:0] q_t;

  localparam int ITERATIONS = 20;
  localparam int GS_ROUNDS  = ITERATIONS - 1;

  localparam int  FRAC_BITS = 40;
  localparam q_t  Q_ONE     = q_t'(64'sd1 <<< FRAC_BITS);
  localparam q_t  Q_TWO     = q_t'(64'sd2 <<< FRAC_BITS);

  // Input clamp, Q3.24
  localparam logic signed [27:0] X_LIM = 28'sd100663296;

  // Output bound, Q1.30
  localparam logic [63:0] OUT_MAX = 64'd1073741824;

  // Constant divider
  localparam int          DIV_D      = 100000;
  localparam int          ROUND_HALF = DIV_D - DIV_D / 2;
  localparam int          REM_W      = 17;
  localparam int          DIV_BITS   = 4;
  localparam int          DIV_STAGES = 64 / DIV_BITS;

  // Polynomial coefficients, w^7 down to w^0, Q40
  localparam q_t POLY [0:7] = '{
    64'sd220058028,
    64'sd1540787552,
    64'sd9162192427,
    64'sd45810842975,
    64'sd183251970698,
    64'sd549755921031,
    64'sd1099511627032,
    64'sd1099511626939
  };

endpackage

// ===== hdl/tanh_poly_exp_goldschmidt.sv =====
// Top level: streaming tanh through exp polynomial, squarings and Goldschmidt reciprocal.
// One sample is taken per cycle and one result leaves per cycle; the whole chain
// advances together and stalls only while a result waits at the output. Each multiply
// cell splits a 64x64 product into four 32x32 partial products over six stages; each
// divider resolves four quotient bits a stage.
module tanh_poly_exp_goldschmidt (
  input  logic                clk,
  input  logic                rst,
  input  logic                x_valid,
  output logic                x_ready,
  input  logic signed [27:0]  x_in,
  output logic                tanh_valid,
  input  logic                tanh_ready,
  output logic signed [31:0]  tanh_out
);
  import tpeg_pkg::*;

  logic en;
  assign en      = !tanh_valid || tanh_ready;
  assign x_ready = en;

  // clamp and scale: w = 2x/16 in Q40
  logic signed [27:0] xc;
  logic               w_vld;
  q_t                 w_r;

  always_comb begin
    xc = x_in;
    if (x_in > X_LIM) xc = X_LIM;
    if (x_in < -X_LIM) xc = -X_LIM;
  end

  always_ff @(posedge clk) begin
    if (rst) w_vld <= 1'b0;
    else if (en) w_vld <= x_valid;
  end

  always_ff @(posedge clk) begin
    if (en) w_r <= q_t'(xc) <<< 13;
  end

  // Horner cells
  q_t   hp [0:7];
  q_t   hw [0:7];
  logic hv [0:7];

  assign hp[0] = POLY[0];
  assign hw[0] = w_r;
  assign hv[0] = w_vld;

  for (genvar i = 1; i < 8; i++) begin : g_horner
    logic m_vld, p_vld;
    q_t   m_y, m_w, p_r, w_q;

    tpeg_qmul u_mul (
      .clk(clk), .rst(rst), .en(en), .in_vld(hv[i-1]),
      .a(hp[i-1]), .b(hw[i-1]), .side_in(hw[i-1]),
      .out_vld(m_vld), .y(m_y), .side_out(m_w)
    );

    always_ff @(posedge clk) begin
      if (rst) p_vld <= 1'b0;
      else if (en) p_vld <= m_vld;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_r <= m_y + POLY[i];
        w_q <= m_w;
      end
    end

    assign hp[i] = p_r;
    assign hw[i] = w_q;
    assign hv[i] = p_vld;
  end

  // squaring cells: p^16
  q_t   sq [0:4];
  logic sv [0:4];

  assign sq[0] = hp[7];
  assign sv[0] = hv[7];

  for (genvar k = 0; k < 4; k++) begin : g_square
    q_t unused_side;
    tpeg_qmul u_sq (
      .clk(clk), .rst(rst), .en(en), .in_vld(sv[k]),
      .a(sq[k]), .b(sq[k]), .side_in(sq[k]),
      .out_vld(sv[k+1]), .y(sq[k+1]), .side_out(unused_side)
    );
  end

  // t = E + 1, then s = t / 100000
  logic t_vld, s_vld;
  q_t   t_r, s_y;

  always_ff @(posedge clk) begin
    if (rst) t_vld <= 1'b0;
    else if (en) t_vld <= sv[4];
  end

  always_ff @(posedge clk) begin
    if (en) t_r <= sq[4] + Q_ONE;
  end

  tpeg_rdiv u_div_s (
    .clk(clk), .rst(rst), .en(en), .in_vld(t_vld), .v(t_r),
    .out_vld(s_vld), .y(s_y)
  );

  // Goldschmidt seed b0 = 1 - s; a0 = 2 - s = 1 + b0 rides the first b cell's side lane
  q_t   ga [0:GS_ROUNDS];
  q_t   gb [0:GS_ROUNDS];
  logic gv [0:GS_ROUNDS];
  logic bv [0:GS_ROUNDS];
  q_t   g_side [0:GS_ROUNDS-1];
  logic g0_vld;
  q_t   b0_r;

  always_ff @(posedge clk) begin
    if (rst) g0_vld <= 1'b0;
    else if (en) g0_vld <= s_vld;
  end

  always_ff @(posedge clk) begin
    if (en) b0_r <= Q_ONE - s_y;
  end

  assign gb[0] = b0_r;
  assign bv[0] = g0_vld;
  // a lane runs one multiply behind b lane: ga[j] lines up with gb[j+1]
  assign ga[0] = g_side[0];
  assign gv[0] = bv[1];

  // Goldschmidt cells: b <- b*b, then a <- a*(1+b) with the new b
  for (genvar j = 0; j < GS_ROUNDS; j++) begin : g_gold
    q_t side_a;

    tpeg_qmul u_b (
      .clk(clk), .rst(rst), .en(en), .in_vld(bv[j]),
      .a(gb[j]), .b(gb[j]), .side_in(Q_ONE + gb[j]),
      .out_vld(bv[j+1]), .y(gb[j+1]), .side_out(g_side[j])
    );

    tpeg_qmul u_a (
      .clk(clk), .rst(rst), .en(en), .in_vld(gv[j]),
      .a(ga[j]), .b(Q_ONE + gb[j+1]), .side_in(ga[j]),
      .out_vld(gv[j+1]), .y(ga[j+1]), .side_out(side_a)
    );
  end

  // r = a / 100000
  logic r_vld;
  q_t   r_y;

  tpeg_rdiv u_div_r (
    .clk(clk), .rst(rst), .en(en), .in_vld(gv[GS_ROUNDS]), .v(ga[GS_ROUNDS]),
    .out_vld(r_vld), .y(r_y)
  );

  // z = 1 - 2r
  logic z_vld;
  q_t   z_r;

  always_ff @(posedge clk) begin
    if (rst) z_vld <= 1'b0;
    else if (en) z_vld <= r_vld;
  end

  always_ff @(posedge clk) begin
    if (en) z_r <= Q_ONE - (r_y <<< 1);
  end

  // Q40 to Q30 with rounding, saturate to +-1
  logic [63:0] zm, zq, zc;

  always_comb begin
    zm = z_r[63] ? 64'(-z_r) : 64'(z_r);
    zq = (zm >> 10) + 64'(zm[9]);
    zc = (zq > OUT_MAX) ? OUT_MAX : zq;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) tanh_valid <= 1'b0;
    else if (en) tanh_valid <= z_vld;
  end

  always_ff @(posedge clk) begin
    if (en) tanh_out <= z_r[63] ? -$signed(zc[31:0]) : $signed(zc[31:0]);
  end

  // checks
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    tanh_valid |-> (tanh_out <= 32'sd1073741824 && tanh_out >= -32'sd1073741824))
    else $error("tanh_out outside [-1, 1]");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (tanh_valid && !tanh_ready) |-> !x_ready)
    else $error("input accepted while output stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (tanh_valid && !tanh_ready) |=> (tanh_valid && $stable(tanh_out)))
    else $error("stalled result changed");

endmodule

// ===== hdl/tpeg_qmul.sv =====
// Pipelined Q40 multiply cell: four 32x32 partial products, rounding, saturation.
module tpeg_qmul (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  tpeg_pkg::q_t  a,
  input  tpeg_pkg::q_t  b,
  input  tpeg_pkg::q_t  side_in,
  output logic          out_vld,
  output tpeg_pkg::q_t  y,
  output tpeg_pkg::q_t  side_out
);
  import tpeg_pkg::*;

  logic [4:0]   vld;
  logic [63:0]  ua [1:4];
  logic [63:0]  ub [1:4];
  logic         neg [1:5];
  q_t           side [1:5];
  logic [127:0] acc [2:5];
  logic [127:0] rnd;
  logic [63:0]  m;

  // rounding and saturation of the full product
  always_comb begin
    rnd = acc[5] + (128'd1 << (FRAC_BITS - 1));
    if (|rnd[127:103]) m = 64'h7FFF_FFFF_FFFF_FFFF;
    else m = {1'b0, rnd[102:40]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[3:0], in_vld};
      out_vld <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes and sign
      ua[1]   <= a[63] ? 64'(-a) : 64'(a);
      ub[1]   <= b[63] ? 64'(-b) : 64'(b);
      neg[1]  <= a[63] ^ b[63];
      side[1] <= side_in;
      // partial products
      acc[2]  <= {64'd0, 64'(ua[1][31:0]) * 64'(ub[1][31:0])};
      acc[3]  <= acc[2] + {32'd0, 64'(ua[2][31:0]) * 64'(ub[2][63:32]), 32'd0};
      acc[4]  <= acc[3] + {32'd0, 64'(ua[3][63:32]) * 64'(ub[3][31:0]), 32'd0};
      acc[5]  <= acc[4] + {64'(ua[4][63:32]) * 64'(ub[4][63:32]), 64'd0};
      for (int k = 2; k <= 4; k++) begin
        ua[k] <= ua[k-1];
        ub[k] <= ub[k-1];
      end
      for (int k = 2; k <= 5; k++) begin
        neg[k]  <= neg[k-1];
        side[k] <= side[k-1];
      end
      y        <= neg[5] ? q_t'(-m) : q_t'(m);
      side_out <= side[5];
    end
  end

endmodule

// ===== hdl/tpeg_rdiv.sv =====
// Pipelined divide by 100000, four quotient bits per stage, rounded half away from zero.
module tpeg_rdiv (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  tpeg_pkg::q_t  v,
  output logic          out_vld,
  output tpeg_pkg::q_t  y
);
  import tpeg_pkg::*;

  logic             vld_s [0:DIV_STAGES];
  logic             neg_s [0:DIV_STAGES];
  logic [63:0]      sh_s  [0:DIV_STAGES];
  logic [REM_W-1:0] rem_s [0:DIV_STAGES];

  logic             vld0, neg0;
  logic [63:0]      mag0;
  logic [63:0]      qm;

  always_ff @(posedge clk) begin
    if (rst) vld0 <= 1'b0;
    else if (en) vld0 <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0 <= v[63] ? 64'(-v) : 64'(v);
      neg0 <= v[63];
    end
  end

  assign vld_s[0] = vld0;
  assign neg_s[0] = neg0;
  assign sh_s[0]  = mag0;
  assign rem_s[0] = '0;

  // restoring division stages
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic             vld_r, neg_r;
    logic [63:0]      sh_r, sh_c;
    logic [REM_W-1:0] rem_r, rem_c;

    always_comb begin
      logic [REM_W:0] t;
      sh_c  = sh_s[g];
      rem_c = rem_s[g];
      for (int k = 0; k < DIV_BITS; k++) begin
        t = {rem_c, sh_c[63]};
        if (t >= (REM_W + 1)'(DIV_D)) begin
          rem_c = REM_W'(t - (REM_W + 1)'(DIV_D));
          sh_c  = {sh_c[62:0], 1'b1};
        end else begin
          rem_c = t[REM_W-1:0];
          sh_c  = {sh_c[62:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld_r <= 1'b0;
      else if (en) vld_r <= vld_s[g];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r <= neg_s[g];
        sh_r  <= sh_c;
        rem_r <= rem_c;
      end
    end

    assign vld_s[g+1] = vld_r;
    assign neg_s[g+1] = neg_r;
    assign sh_s[g+1]  = sh_r;
    assign rem_s[g+1] = rem_r;
  end

  // round and restore the sign
  assign qm = sh_s[DIV_STAGES] +
              64'(rem_s[DIV_STAGES] >= REM_W'(ROUND_HALF));

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= vld_s[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) y <= neg_s[DIV_STAGES] ? q_t'(-qm) : q_t'(qm);
  end

endmodule
